// ----- rtl/core/sha256_byte_stream_hasher_top_macros.svh -----
// Assertion macros for the SHA-256 byte stream hasher checker.
// Used by the checker file only; no other dependencies.
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("check failed");
// implication checked in the next cycle
`define CHK_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("check failed");
`endif

// ----- rtl/core/sha_pkg.sv -----
// Package for the SHA-256 byte stream hasher: payload types and constants.
// No dependencies.
`default_nettype none
package sha_pkg;
	typedef struct packed {
		logic [7:0] msg_byte;
		logic       has_byte;
		logic       end_of_msg;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_word_t;

	localparam logic [31:0] PadWord = 32'h80000000;

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		case (i)
			3'd0: init_hash = 32'h6a09e667;
			3'd1: init_hash = 32'hbb67ae85;
			3'd2: init_hash = 32'h3c6ef372;
			3'd3: init_hash = 32'ha54ff53a;
			3'd4: init_hash = 32'h510e527f;
			3'd5: init_hash = 32'h9b05688c;
			3'd6: init_hash = 32'h1f83d9ab;
			default: init_hash = 32'h5be0cd19;
		endcase
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};
		round_k = k[r];
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/sha_round.sv -----
// One SHA-256 round datapath plus schedule expansion, shared by all 64 rounds.
// Depends on sha_pkg for the round constants.
`default_nettype none
module sha_round (
	input  wire logic [255:0] vars,
	input  wire logic [511:0] sched,
	input  wire logic [5:0]   rnd,
	output logic      [255:0] vars_nxt,
	output logic      [31:0]  w
);
	import sha_pkg::*;

	logic [31:0] a, b, c, d, e, f, g, h, t1, t2, x15, x2, x16, x7;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	// schedule is a shift line: word 0 oldest, word 15 newest
	always_comb begin
		x16 = sched[511:480];
		x15 = sched[479:448];
		x7  = sched[223:192];
		x2  = sched[63:32];
		if (rnd < 6'd16)
			w = sched[511:480];
		else
			w = (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10)) + x7
				+ (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3)) + x16;
		{a, b, c, d, e, f, g, h} = vars;
		t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
			+ round_k(rnd) + w;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
		vars_nxt = {t1 + t2, a, b, c, d + t1, e, f, g};
	end
endmodule
`default_nettype wire

// ----- rtl/core/sha256_byte_stream_hasher_top.sv -----
// SHA-256 byte stream hasher, top level.
// Depends on sha_pkg and sha_round.
//
// Bytes enter one per accepted word and are packed big-endian into a 16-word
// block buffer. Each full block runs 64 rounds on the shared round unit, one
// round per cycle, then ST_ADD folds the result into the chaining value;
// input is not ready meanwhile. An end word pads the message (one or two
// blocks), then the eight digest words leave through the output register,
// index 0 first, last_word on the eighth; a new message may start once the
// last digest word is taken. A has_byte=0 end word adds no byte; sent first,
// it hashes the empty message.
`default_nettype none
module sha256_byte_stream_hasher_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire sha_pkg::in_word_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output sha_pkg::out_word_t       out_data
);
	import sha_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RND  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_PAD  = 3'd3;
	localparam logic [2:0] ST_LEN  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]   state_q;
	logic [255:0] chain_q, vars_q, vars_nxt;
	logic [511:0] sched_q;
	logic [5:0]   cnt_q, rnd_q;
	logic [63:0]  bits_q;
	logic         fin_q;     // padding pending after this compression
	logic         lenblk_q;  // the block being compressed is the last one
	logic         padded_q;  // 0x80 already placed; the extra block is all zero
	logic [2:0]   oidx_q;
	logic [31:0]  w;

	sha_round u_round (.vars(vars_q), .sched(sched_q), .rnd(rnd_q),
		.vars_nxt(vars_nxt), .w(w));

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	always_comb begin
		out_data.digest_word = chain_q[255 - 32*oidx_q -: 32];
		out_data.word_index  = oidx_q;
		out_data.last_word   = (oidx_q == 3'd7);
	end

	function automatic logic [255:0] iv();
		logic [255:0] v;
		for (int i = 0; i < 8; i++) v[255 - 32*i -: 32] = init_hash(3'(i));
		return v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chain_q <= iv();
			vars_q <= iv();
			sched_q <= '0;
			cnt_q <= '0;
			bits_q <= '0;
			fin_q <= 1'b0;
			lenblk_q <= 1'b0;
			padded_q <= 1'b0;
			oidx_q <= '0;
			rnd_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						fin_q <= in_data.end_of_msg;
						if (in_data.has_byte) begin
							sched_q[511 - 8*cnt_q -: 8] <= in_data.msg_byte;
							bits_q <= bits_q + 64'd8;
							cnt_q <= cnt_q + 6'd1;
							if (cnt_q == 6'd63) begin
								state_q <= ST_RND;
								rnd_q <= '0;
								vars_q <= chain_q;
								lenblk_q <= 1'b0;
							end else if (in_data.end_of_msg) state_q <= ST_PAD;
						end else if (in_data.end_of_msg) state_q <= ST_PAD;
					end
				end
				ST_RND: begin
					vars_q <= vars_nxt;
					sched_q <= {sched_q[479:0], w};
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++)
						chain_q[255 - 32*i -: 32] <= chain_q[255 - 32*i -: 32]
							+ vars_q[255 - 32*i -: 32];
					if (lenblk_q) begin
						state_q <= ST_OUT;
						oidx_q <= '0;
					end else if (fin_q) state_q <= (cnt_q == 6'd0) ? ST_LEN : ST_PAD;
					else state_q <= ST_IDLE;
					// fresh final block: 0x80 first unless it already went into the last one
					if (!lenblk_q && fin_q && cnt_q == 6'd0)
						sched_q <= padded_q ? 512'd0 : {PadWord, 480'd0};
				end
				ST_PAD: begin
					// 0x80 after last byte, zeros to the end of the block
					for (int j = 0; j < 64; j++)
						if (6'(j) == cnt_q) sched_q[511 - 8*j -: 8] <= 8'h80;
						else if (6'(j) > cnt_q) sched_q[511 - 8*j -: 8] <= 8'h00;
					if (cnt_q >= 6'd56) begin
						// length does not fit: compress, then a zero block
						cnt_q <= '0;
						state_q <= ST_RND;
						rnd_q <= '0;
						vars_q <= chain_q;
						lenblk_q <= 1'b0;
						fin_q <= 1'b1;
						padded_q <= 1'b1;
					end else state_q <= ST_LEN;
				end
				ST_LEN: begin
					sched_q[63:0] <= bits_q;
					state_q <= ST_RND;
					rnd_q <= '0;
					vars_q <= chain_q;
					lenblk_q <= 1'b1;
				end
				ST_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= ST_IDLE;
							chain_q <= iv();
							cnt_q <= '0;
							bits_q <= '0;
							fin_q <= 1'b0;
							lenblk_q <= 1'b0;
							padded_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/sha_checker.sv -----
// Port-level checker for the SHA-256 hasher, bound to the top level.
// Depends on sha_pkg and the assertion macro header.
`default_nettype none
`include "sha256_byte_stream_hasher_top_macros.svh"
module sha_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire sha_pkg::out_word_t out_data
);
	import sha_pkg::*;
	`CHK_IMPL(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`CHK_NEXT(a_idx_step, clk, arst_n, out_valid && out_ready && !out_data.last_word,
		out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
	`CHK_NEXT(a_done, clk, arst_n, out_valid && out_ready && out_data.last_word,
		!out_valid && in_ready)
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind sha256_byte_stream_hasher_top sha_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .out_data(out_data));
`default_nettype wire
